// File: src/stig_pkg.sv
package stig_pkg;

	localparam int DEPTH_DEF = 16;

	localparam int VAL_W = 32;
	localparam int POS_W = 4;
	localparam int MODE_W = 2;
	localparam int ST_W = 2;
	localparam int CNT_OUT_W = 5;

	// stream payload widths, padded to whole bytes
	localparam int S_DATA_W = 40;
	localparam int M_DATA_W = 40;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_INDEX = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic ins_start;
		logic ins_shift;
		logic ins_place;
		logic get_rd;
		logic get_take;
		logic del_start;
		logic del_shift;
		logic cnt_inc;
		logic cnt_dec;
		logic set_st;
		logic [ST_W-1:0] st_code;
		logic out_load;
	} stig_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic full;
		logic empty;
		logic pos_bad;
		logic del_last;
		logic greater;
		logic ptr_one;
		logic del_more;
		logic out_free;
	} stig_stat_t;

endpackage

// File: src/sorted_table_insert_get_delete.sv
// Sorted table of up to DEPTH signed 32-bit values kept in ascending order, held in one
// single-write RAM with registered read. Each item on the slave stream is a request
// (insert, get by position, delete by position) and gives exactly one result item with
// the value read (get only, else zero), a status (ok, position beyond count, full) and
// the entry count after the request. One item is worked at a time: the request is decoded,
// then get reads the entry at its position, insert scans down from the top entry shifting
// each entry greater than the new value up one place and then writes the new value, and
// delete moves each entry above the deleted position down one place; refused and unused
// requests go straight to the result. Entries move one per cycle through the RAM port. A
// finished result waits in an output register while the next item is accepted.
module sorted_table_insert_get_delete #(
	parameter int DEPTH = stig_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [stig_pkg::S_DATA_W-1:0] s_tdata,  // value_in[31:0], position[35:32], zero pad
	input  logic [stig_pkg::MODE_W-1:0]   s_tuser,  // mode[1:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [stig_pkg::M_DATA_W-1:0] m_tdata,  // value_out[31:0], entry_count[36:32], zero pad
	output logic [stig_pkg::ST_W-1:0]     m_tuser   // status[1:0]
);
	import stig_pkg::*;

	stig_cmd_t  cmd;
	stig_stat_t stat;

	stig_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	stig_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.cmd     (cmd),
		.stat    (stat)
	);

endmodule

// File: src/stig_ram.sv
module stig_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/stig_ctrl.sv
module stig_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  stig_pkg::stig_stat_t stat,
	output stig_pkg::stig_cmd_t  cmd
);
	import stig_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DECODE   = 7'b0000010,
		S_INS      = 7'b0000100,
		S_INS_LAST = 7'b0001000,
		S_GET      = 7'b0010000,
		S_DEL      = 7'b0100000,
		S_FIN      = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.st_code = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.mode)
					MODE_INSERT: begin
						if (stat.full) begin
							cmd.set_st = 1'b1;
							cmd.st_code = ST_FULL;
							state_d = S_FIN;
						end else begin
							// scan from the top entry down, shifting larger ones up
							cmd.ins_start = 1'b1;
							state_d = stat.empty ? S_INS_LAST : S_INS;
						end
					end
					MODE_GET: begin
						if (stat.pos_bad) begin
							cmd.set_st = 1'b1;
							cmd.st_code = ST_INDEX;
							state_d = S_FIN;
						end else begin
							cmd.get_rd = 1'b1;
							state_d = S_GET;
						end
					end
					MODE_DELETE: begin
						if (stat.pos_bad) begin
							cmd.set_st = 1'b1;
							cmd.st_code = ST_INDEX;
							state_d = S_FIN;
						end else if (stat.del_last) begin
							cmd.cnt_dec = 1'b1;
							state_d = S_FIN;
						end else begin
							cmd.del_start = 1'b1;
							state_d = S_DEL;
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_INS: begin
				if (stat.greater) begin
					cmd.ins_shift = 1'b1;
					if (stat.ptr_one) begin
						state_d = S_INS_LAST;
					end
				end else begin
					cmd.ins_place = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d = S_FIN;
				end
			end
			S_INS_LAST: begin
				cmd.ins_place = 1'b1;
				cmd.cnt_inc = 1'b1;
				state_d = S_FIN;
			end
			S_GET: begin
				cmd.get_take = 1'b1;
				state_d = S_FIN;
			end
			S_DEL: begin
				cmd.del_shift = 1'b1;
				if (!stat.del_more) begin
					cmd.cnt_dec = 1'b1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// File: src/stig_dp.sv
module stig_dp #(
	parameter int DEPTH = stig_pkg::DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [stig_pkg::S_DATA_W-1:0]   s_tdata,
	input  logic [stig_pkg::MODE_W-1:0]     s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [stig_pkg::M_DATA_W-1:0]   m_tdata,
	output logic [stig_pkg::ST_W-1:0]       m_tuser,
	input  stig_pkg::stig_cmd_t             cmd,
	output stig_pkg::stig_stat_t            stat
);
	import stig_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [MODE_W-1:0] mode_q;
	logic [VAL_W-1:0]  val_q;
	logic [POS_W-1:0]  pos_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic [VAL_W-1:0]  value_q;
	logic [ST_W-1:0]   status_q;
	logic              m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [ST_W-1:0]   m_tuser_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [VAL_W-1:0]  ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [VAL_W-1:0]  ram_rdata;

	stig_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ram_we = cmd.ins_shift | cmd.ins_place | cmd.del_shift;
	assign ram_waddr = AW'(ptr_q);
	assign ram_wdata = cmd.ins_place ? val_q : ram_rdata;

	always_comb begin
		ram_raddr = '0;
		if (cmd.ins_start) begin
			ram_raddr = AW'(count_q - CW'(1));
		end else if (cmd.ins_shift) begin
			ram_raddr = AW'(ptr_q - CW'(2));
		end else if (cmd.get_rd) begin
			ram_raddr = AW'(pos_q);
		end else if (cmd.del_start) begin
			ram_raddr = AW'(PW'(pos_q) + PW'(1));
		end else if (cmd.del_shift) begin
			ram_raddr = AW'(ptr_q + CW'(2));
		end
	end

	always_comb begin
		stat.mode = mode_q;
		stat.full = (count_q == CW'(DEPTH));
		stat.empty = (count_q == '0);
		stat.pos_bad = (PW'(pos_q) >= PW'(count_q));
		stat.del_last = ((PW'(pos_q) + PW'(1)) >= PW'(count_q));
		stat.greater = ($signed(ram_rdata) > $signed(val_q));
		stat.ptr_one = (ptr_q == CW'(1));
		stat.del_more = ((PW'(ptr_q) + PW'(2)) < PW'(count_q));
		stat.out_free = !m_tvalid_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= s_tuser;
			val_q <= s_tdata[VAL_W-1:0];
			pos_q <= s_tdata[VAL_W+POS_W-1:VAL_W];
			value_q <= '0;
			status_q <= ST_OK;
		end
		if (cmd.set_st) begin
			status_q <= cmd.st_code;
		end
		if (cmd.get_take) begin
			value_q <= ram_rdata;
		end
		// one pointer serves both passes: insert slot going down, delete hole going up
		if (cmd.ins_start) begin
			ptr_q <= count_q;
		end else if (cmd.ins_shift) begin
			ptr_q <= ptr_q - CW'(1);
		end else if (cmd.del_start) begin
			ptr_q <= CW'(pos_q);
		end else if (cmd.del_shift) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.out_load) begin
			m_tdata_q <= {{(M_DATA_W - VAL_W - CNT_OUT_W){1'b0}}, CNT_OUT_W'(count_q), value_q};
			m_tuser_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_no_inc_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (count_q != CW'(DEPTH)))
		else $error("insert into full table");

	a_no_dec_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (count_q != '0))
		else $error("delete from empty table");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ptr_q <= count_q) && (ptr_q < CW'(DEPTH)))
		else $error("store written outside its live range");

	a_load_only_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid_q || m_tready))
		else $error("result overwritten before taken");

endmodule
